// ===== rtl/block_buffer_cache_lru_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block buffer cache
// Shared concurrent-assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbc assertion failed");

// next-cycle implication
`define BBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbc assertion failed");

`endif

// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, constants and codes shared by the block buffer cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int NUM_BUFFERS = 16;
    localparam int BUF_IW      = $clog2(NUM_BUFFERS);
    localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int IN_W        = 40;
    localparam int OUT_W       = 40;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WNOW  = 3'd1;
    localparam logic [2:0] KIND_DWR   = 3'd2;
    localparam logic [2:0] KIND_REL   = 3'd3;
    localparam logic [2:0] KIND_FLUSH = 3'd4;

    localparam logic [1:0] IO_NONE  = 2'd0;
    localparam logic [1:0] IO_READ  = 2'd1;
    localparam logic [1:0] IO_WRITE = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [7:0]  dev;
        logic [23:0] blk;
        logic        done;
        logic        dirty;
        logic        onfree;
    } t_rec;

    typedef struct packed {
        logic [BUF_IW-1:0] nxt;
        logic [BUF_IW-1:0] prv;
    } t_link;

    typedef struct packed {
        logic              en;
        logic [BUF_IW-1:0] addr;
        t_rec              data;
    } t_tag_wr;

    typedef struct packed {
        logic              en_nxt;
        logic              en_prv;
        logic [BUF_IW-1:0] addr;
        t_link             data;
    } t_link_wr;

    typedef struct packed {
        logic        last;
        logic        status;
        logic [23:0] io_block;
        logic [7:0]  io_device;
        logic [1:0]  io_op;
        logic        hit;
        logic [3:0]  idx;
    } t_res;

endpackage

// ===== rtl/block_buffer_cache_lru.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Block buffer cache with tag search and an LRU free list held in memory.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass sets up the tag and link
// memories; no request is taken meanwhile. A read request scans the tag memory
// one buffer per cycle until a hit or the last buffer, then does the record
// update and four link-memory steps before it sends its results; a release
// does the record update and the same link-memory steps. A flush visits the
// free list from its head, reading each buffer and skipping it or writing it
// back through the record update and link-memory steps; the link memory has a
// single write port. Results leave through an output register, so a waiting
// result stalls only the next result.
`timescale 1ns / 1ps

module block_buffer_cache_lru (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] kind
    input  logic [2:0]  i_s_tuser,
    // [7:0] device, [31:8] block, [35:32] buffer_sel, [39:36] zero
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] buffer_index, [4] hit, [6:5] io_op, [14:7] io_device,
    // [38:15] io_block, [39] status
    output logic [39:0] o_m_tdata,
    output logic        o_m_tlast
);
    import bbc_pkg::*;

    typedef enum logic [14:0] {
        S_INIT    = 15'h0001,
        S_IDLE    = 15'h0002,
        S_SRCH    = 15'h0004,
        S_RD      = 15'h0008,
        S_CAP     = 15'h0010,
        S_DEC     = 15'h0020,
        S_RM1     = 15'h0040,
        S_RM2     = 15'h0080,
        S_AP1     = 15'h0100,
        S_AP2     = 15'h0200,
        S_POST    = 15'h0400,
        S_EMIT    = 15'h0800,
        S_FL_PUSH = 15'h1000,
        S_FL_NEXT = 15'h2000,
        S_FL_END  = 15'h4000
    } t_state;

    t_state r_state, r_ret;

    logic [2:0]        r_kind;
    logic [7:0]        r_dev;
    logic [23:0]       r_blk;
    logic [BUF_IW:0]   r_ptr;
    logic [BUF_IW-1:0] r_chk, r_addr, r_cur, r_nxt, r_head, r_tail;
    logic              r_chkv, r_hit, r_rm, r_ap, r_more, r_pend_v, r_out_v;
    logic [CNT_W-1:0]  r_count, r_steps, r_s;
    logic [RES_W-1:0]  r_n;
    t_rec              r_rec;
    t_link             r_lnk;
    t_res              r_res, r_res2, r_pend, r_fres, r_out;

    logic [BUF_IW-1:0] w_raddr;
    t_tag_wr           w_tag_wr;
    t_link_wr          w_link_wr;
    t_rec              w_tag_q, w_new;
    t_link             w_link_q;
    logic              w_rm, w_ap, w_wr, w_fmatch, w_smatch, w_out_ld;
    logic [BUF_IW-1:0] w_ini;

    bbc_store u_store (
        .i_clk     (i_clk),
        .i_raddr   (w_raddr),
        .i_tag_wr  (w_tag_wr),
        .i_link_wr (w_link_wr),
        .o_tag_q   (w_tag_q),
        .o_link_q  (w_link_q)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out.status, r_out.io_block, r_out.io_device,
                         r_out.io_op, r_out.hit, r_out.idx};
    assign o_m_tlast  = r_out.last;
    assign w_out_ld   = (r_state == S_EMIT) && (!r_out_v || i_m_tready);

    assign w_ini    = r_ptr[BUF_IW-1:0];
    assign w_raddr  = (r_state == S_SRCH) ? r_ptr[BUF_IW-1:0] : r_addr;
    assign w_smatch = w_tag_q.valid && (w_tag_q.dev == r_dev) && (w_tag_q.blk == r_blk);
    assign w_rm     = r_rec.onfree && (r_count != '0);
    assign w_fmatch = r_rec.dirty && r_rec.valid && (r_rec.dev == r_dev);

    // record update decided from the captured entry
    always_comb begin
        w_new = r_rec;
        w_wr  = 1'b0;
        w_ap  = 1'b0;
        case (r_kind)
            KIND_READ: begin
                w_wr = 1'b1;
                if (!r_hit) begin
                    w_new.valid = 1'b1;
                    w_new.dev   = r_dev;
                    w_new.blk   = r_blk;
                    w_new.dirty = 1'b0;
                end
                w_new.done   = 1'b1;
                w_new.onfree = w_rm ? 1'b0 : r_rec.onfree;
            end
            KIND_WNOW, KIND_DWR, KIND_REL: begin
                w_wr = 1'b1;
                w_ap = !r_rec.onfree;
                if (r_rec.valid && r_kind == KIND_WNOW) begin
                    w_new.dirty = 1'b0;
                    w_new.done  = 1'b1;
                end
                if (r_rec.valid && r_kind == KIND_DWR) begin
                    w_new.dirty = 1'b1;
                    w_new.done  = 1'b1;
                end
                w_new.onfree = 1'b1;
            end
            KIND_FLUSH: begin
                w_wr         = w_fmatch;
                w_ap         = w_rm || !r_rec.onfree;
                w_new.dirty  = 1'b0;
                w_new.done   = 1'b1;
                w_new.onfree = 1'b1;
            end
            default: begin
                w_wr = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_tag_wr  = '{en: 1'b0, addr: r_cur, data: w_new};
        w_link_wr = '{en_nxt: 1'b0, en_prv: 1'b0, addr: r_cur, data: r_lnk};
        case (r_state)
            S_INIT: begin
                w_tag_wr.en     = 1'b1;
                w_tag_wr.addr   = w_ini;
                w_tag_wr.data   = '{valid: 1'b0, dev: '0, blk: '0, done: 1'b0,
                                    dirty: 1'b0, onfree: 1'b1};
                w_link_wr.en_nxt   = 1'b1;
                w_link_wr.en_prv   = 1'b1;
                w_link_wr.addr     = w_ini;
                w_link_wr.data.nxt = (w_ini != '0) ? w_ini - 1'b1 : '0;
                w_link_wr.data.prv = (w_ini != BUF_IW'(NUM_BUFFERS - 1)) ? w_ini + 1'b1 : '0;
            end
            S_DEC: begin
                w_tag_wr.en = w_wr;
            end
            S_RM1: begin
                w_link_wr.en_nxt   = r_rm && (r_cur != r_head);
                w_link_wr.addr     = r_lnk.prv;
                w_link_wr.data.nxt = r_lnk.nxt;
            end
            S_RM2: begin
                w_link_wr.en_prv   = r_rm && (r_cur != r_tail);
                w_link_wr.addr     = r_lnk.nxt;
                w_link_wr.data.prv = r_lnk.prv;
            end
            S_AP1: begin
                w_link_wr.en_nxt   = r_ap && (r_count != '0);
                w_link_wr.addr     = r_tail;
                w_link_wr.data.nxt = r_cur;
            end
            S_AP2: begin
                w_link_wr.en_prv   = r_ap && (r_count != '0);
                w_link_wr.addr     = r_cur;
                w_link_wr.data.prv = r_tail;
            end
            default: begin
                w_tag_wr.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ret    <= S_IDLE;
            r_ptr    <= '0;
            r_chkv   <= 1'b0;
            r_head   <= BUF_IW'(NUM_BUFFERS - 1);
            r_tail   <= '0;
            r_count  <= CNT_W'(NUM_BUFFERS);
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_more   <= 1'b0;
            r_rm     <= 1'b0;
            r_ap     <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (w_out_ld) begin
                r_out_v <= 1'b1;
                r_out   <= r_res;
            end else if (r_out_v && i_m_tready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (w_ini == BUF_IW'(NUM_BUFFERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind <= i_s_tuser;
                        r_dev  <= i_s_tdata[7:0];
                        r_blk  <= i_s_tdata[31:8];
                        r_more <= 1'b0;
                        r_ret  <= S_IDLE;
                        r_res  <= '{last: 1'b1, default: '0};
                        case (i_s_tuser)
                            KIND_READ: begin
                                r_ptr   <= '0;
                                r_chkv  <= 1'b0;
                                r_state <= S_SRCH;
                            end
                            KIND_WNOW, KIND_DWR, KIND_REL: begin
                                r_addr  <= i_s_tdata[35:32];
                                r_cur   <= i_s_tdata[35:32];
                                r_state <= S_RD;
                            end
                            KIND_FLUSH: begin
                                r_n      <= '0;
                                r_s      <= '0;
                                r_steps  <= r_count;
                                r_pend_v <= 1'b0;
                                r_addr   <= r_head;
                                r_cur    <= r_head;
                                r_state  <= (r_count == '0) ? S_FL_END : S_RD;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    r_ptr  <= r_ptr + 1'b1;
                    r_chk  <= r_ptr[BUF_IW-1:0];
                    r_chkv <= 1'b1;
                    if (r_chkv && w_smatch) begin
                        r_hit   <= 1'b1;
                        r_cur   <= r_chk;
                        r_rec   <= w_tag_q;
                        r_lnk   <= w_link_q;
                        r_state <= S_DEC;
                    end else if (r_chkv && r_chk == BUF_IW'(NUM_BUFFERS - 1)) begin
                        r_hit <= 1'b0;
                        if (r_count == '0) begin
                            r_res.status <= 1'b1;
                            r_state      <= S_EMIT;
                        end else begin
                            r_addr  <= r_head;
                            r_cur   <= r_head;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_rec   <= w_tag_q;
                    r_lnk   <= w_link_q;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_nxt <= r_lnk.nxt;
                    case (r_kind)
                        KIND_READ: begin
                            r_ap    <= w_ap;
                            r_rm    <= w_rm;
                            r_state <= S_RM1;
                            if (r_hit) begin
                                r_res <= '{last: 1'b1, status: 1'b0,
                                           io_block: r_rec.done ? '0 : r_blk,
                                           io_device: r_rec.done ? '0 : r_dev,
                                           io_op: r_rec.done ? IO_NONE : IO_READ,
                                           hit: 1'b1, idx: r_cur};
                            end else if (r_rec.dirty && r_rec.valid) begin
                                // write back the old tag ahead of the read
                                r_res  <= '{last: 1'b0, status: 1'b0,
                                            io_block: r_rec.blk, io_device: r_rec.dev,
                                            io_op: IO_WRITE, hit: 1'b0, idx: r_cur};
                                r_res2 <= '{last: 1'b1, status: 1'b0, io_block: r_blk,
                                            io_device: r_dev, io_op: IO_READ,
                                            hit: 1'b0, idx: r_cur};
                                r_more <= 1'b1;
                            end else begin
                                r_res <= '{last: 1'b1, status: 1'b0, io_block: r_blk,
                                           io_device: r_dev, io_op: IO_READ,
                                           hit: 1'b0, idx: r_cur};
                            end
                        end
                        KIND_FLUSH: begin
                            r_rm    <= w_fmatch && w_rm;
                            r_ap    <= w_fmatch && w_ap;
                            r_fres  <= '{last: 1'b0, status: 1'b0, io_block: r_rec.blk,
                                         io_device: r_rec.dev, io_op: IO_WRITE,
                                         hit: 1'b0, idx: r_cur};
                            r_state <= w_fmatch ? S_RM1 : S_FL_NEXT;
                        end
                        default: begin
                            r_ap    <= w_ap;
                            r_rm    <= 1'b0;
                            r_state <= S_RM1;
                            if (r_kind == KIND_WNOW && r_rec.valid) begin
                                r_res <= '{last: 1'b1, status: 1'b0, io_block: r_rec.blk,
                                           io_device: r_rec.dev, io_op: IO_WRITE,
                                           hit: 1'b0, idx: r_cur};
                            end else begin
                                r_res <= '{last: 1'b1, status: 1'b0, io_block: '0,
                                           io_device: '0, io_op: IO_NONE,
                                           hit: 1'b0, idx: r_cur};
                            end
                        end
                    endcase
                end
                S_RM1: begin
                    if (r_rm && r_cur == r_head) begin
                        r_head <= r_lnk.nxt;
                    end
                    r_state <= S_RM2;
                end
                S_RM2: begin
                    if (r_rm) begin
                        if (r_cur == r_tail) begin
                            r_tail <= r_lnk.prv;
                        end
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= S_AP1;
                end
                S_AP1: begin
                    if (r_ap && r_count == '0) begin
                        r_head <= r_cur;
                    end
                    r_state <= S_AP2;
                end
                S_AP2: begin
                    if (r_ap) begin
                        r_tail  <= r_cur;
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_state <= (r_kind == KIND_FLUSH) ? S_FL_PUSH : S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_ld) begin
                        if (r_more) begin
                            r_res  <= r_res2;
                            r_more <= 1'b0;
                        end else begin
                            r_state <= r_ret;
                        end
                    end
                end
                S_FL_PUSH: begin
                    // hold the newest write back until its last flag is known
                    r_pend   <= r_fres;
                    r_pend_v <= 1'b1;
                    r_n      <= r_n + 1'b1;
                    if (r_pend_v) begin
                        r_res   <= r_pend;
                        r_ret   <= S_FL_NEXT;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_FL_NEXT;
                    end
                end
                S_FL_NEXT: begin
                    if (CNT_W'(r_s + 1'b1) == r_steps || r_n == RES_W'(MAX_RESULTS)) begin
                        r_state <= S_FL_END;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_addr  <= r_nxt;
                        r_cur   <= r_nxt;
                        r_state <= S_RD;
                    end
                end
                S_FL_END: begin
                    if (r_pend_v) begin
                        r_res <= '{last: 1'b1, status: r_pend.status,
                                   io_block: r_pend.io_block, io_device: r_pend.io_device,
                                   io_op: r_pend.io_op, hit: r_pend.hit, idx: r_pend.idx};
                    end else begin
                        r_res <= '{last: 1'b1, default: '0};
                    end
                    r_ret   <= S_IDLE;
                    r_state <= S_EMIT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/bbc_store.sv =====
// ----------------------------------------------------------------------------
// bbc_store
// Tag memory and link memory, one read address for both, with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_store (
    input  logic                      i_clk,
    input  logic [bbc_pkg::BUF_IW-1:0] i_raddr,
    input  bbc_pkg::t_tag_wr          i_tag_wr,
    input  bbc_pkg::t_link_wr         i_link_wr,
    output bbc_pkg::t_rec             o_tag_q,
    output bbc_pkg::t_link            o_link_q
);
    import bbc_pkg::*;

    t_rec  tag_mem  [NUM_BUFFERS];
    t_link link_mem [NUM_BUFFERS];

    always_ff @(posedge i_clk) begin
        if (i_tag_wr.en) begin
            tag_mem[i_tag_wr.addr] <= i_tag_wr.data;
        end
        o_tag_q <= tag_mem[i_raddr];
    end

    // field-masked write on the link entry
    always_ff @(posedge i_clk) begin
        if (i_link_wr.en_nxt) begin
            link_mem[i_link_wr.addr].nxt <= i_link_wr.data.nxt;
        end
        if (i_link_wr.en_prv) begin
            link_mem[i_link_wr.addr].prv <= i_link_wr.data.prv;
        end
        o_link_q <= link_mem[i_raddr];
    end

endmodule

// ===== rtl/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks on the result stream of the block buffer cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_buffer_cache_lru_assert.svh"

module bbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata,
    input logic        i_m_tlast
);
    import bbc_pkg::*;

    logic w_acc;
    assign w_acc = i_m_tvalid && i_m_tready;

    `BBC_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)
    `BBC_ASSERT_IMP(a_idle_io_zero, i_clk, i_rst_n, w_acc && i_m_tdata[6:5] == IO_NONE,
                    i_m_tdata[38:7] == '0)
    `BBC_ASSERT_IMP(a_busy_single, i_clk, i_rst_n, w_acc && i_m_tdata[39],
                    i_m_tlast && i_m_tdata[6:5] == IO_NONE && !i_m_tdata[4])
    `BBC_ASSERT_IMP(a_hit_last, i_clk, i_rst_n, w_acc && i_m_tdata[4], i_m_tlast)
    `BBC_ASSERT_IMP(a_op_legal, i_clk, i_rst_n, w_acc, i_m_tdata[6:5] != 2'd3)

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);

// ===== test/tb_block_buffer_cache_lru.sv =====
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru
// Streams all request kinds into the buffer cache, tracks the
// tag store and LRU free list in a local predictor, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_buffer_cache_lru;
    import bbc_pkg::*;

    localparam int N_RANDOM = 435;
    localparam int CALM_TAIL = 60;
    localparam logic [2:0] KIND_BAD = 3'd7;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  dev;
        logic [23:0] blk;
        logic [3:0]  sel;
        bit          drain;
    } t_req;

    typedef struct {
        logic [3:0]  idx;
        logic        hit;
        logic [1:0]  op;
        logic [7:0]  dev;
        logic [23:0] blk;
        logic        status;
        logic        last;
    } t_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser = '0;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    block_buffer_cache_lru i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the cache state
    logic [7:0]  tag_dev   [NUM_BUFFERS];
    logic [23:0] tag_blk   [NUM_BUFFERS];
    bit          tag_ok    [NUM_BUFFERS];
    bit          done_b    [NUM_BUFFERS];
    bit          dirty_b   [NUM_BUFFERS];
    bit          free_b    [NUM_BUFFERS];
    logic [3:0]  nxt_b     [NUM_BUFFERS];
    logic [3:0]  prv_b     [NUM_BUFFERS];
    logic [3:0]  head_b, tail_b;
    int          free_cnt;

    t_req pending_reqs[$];
    t_exp expected_results[$];
    t_req cur_req;
    int   errors = 0;
    int   src_gap = 0;
    int   sink_gap = 0;
    bit   calm = 1'b0;
    bit   stim_done = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void unlink_buf(input int i);
        if (!free_b[i] || free_cnt == 0) return;
        if (i == head_b) head_b = nxt_b[i];
        else nxt_b[prv_b[i]] = nxt_b[i];
        if (i == tail_b) tail_b = prv_b[i];
        else prv_b[nxt_b[i]] = prv_b[i];
        free_b[i] = 1'b0;
        free_cnt--;
    endfunction

    function automatic void append_buf(input int i);
        if (free_b[i]) return;
        if (free_cnt == 0) head_b = 4'(i);
        else begin
            nxt_b[tail_b] = 4'(i);
            prv_b[i] = tail_b;
        end
        tail_b = 4'(i);
        free_b[i] = 1'b1;
        free_cnt++;
    endfunction

    function automatic void push_res(input int idx, input bit hit, input logic [1:0] op,
                                     input logic [7:0] dev, input logic [23:0] blk,
                                     input bit st, input bit last);
        t_exp r;
        r.idx = 4'(idx); r.hit = hit; r.op = op; r.dev = dev; r.blk = blk;
        r.status = st; r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_cache(input t_req q);
        int i;
        int cur;
        int nx;
        int steps;
        int n;
        if (q.kind == KIND_READ) begin
            for (i = 0; i < NUM_BUFFERS; i++) begin
                if (tag_ok[i] && tag_dev[i] == q.dev && tag_blk[i] == q.blk) begin
                    unlink_buf(i);
                    if (done_b[i]) push_res(i, 1, IO_NONE, 0, 0, 0, 1);
                    else begin
                        done_b[i] = 1'b1;
                        push_res(i, 1, IO_READ, q.dev, q.blk, 0, 1);
                    end
                    return;
                end
            end
            if (free_cnt == 0) begin
                push_res(0, 0, IO_NONE, 0, 0, 1, 1);
                return;
            end
            i = head_b;
            unlink_buf(i);
            if (dirty_b[i] && tag_ok[i]) push_res(i, 0, IO_WRITE, tag_dev[i], tag_blk[i], 0, 0);
            tag_dev[i] = q.dev; tag_blk[i] = q.blk; tag_ok[i] = 1'b1;
            dirty_b[i] = 1'b0; done_b[i] = 1'b1;
            push_res(i, 0, IO_READ, q.dev, q.blk, 0, 1);
        end else if (q.kind == KIND_FLUSH) begin
            cur = head_b; steps = free_cnt; n = 0;
            for (i = 0; i < steps && n < MAX_RESULTS; i++) begin
                nx = nxt_b[cur];
                if (dirty_b[cur] && tag_ok[cur] && tag_dev[cur] == q.dev) begin
                    dirty_b[cur] = 1'b0; done_b[cur] = 1'b1;
                    unlink_buf(cur);
                    append_buf(cur);
                    push_res(cur, 0, IO_WRITE, tag_dev[cur], tag_blk[cur], 0, 0);
                    n++;
                end
                cur = nx;
            end
            if (n == 0) push_res(0, 0, IO_NONE, 0, 0, 0, 1);
            else expected_results[$].last = 1'b1;
        end else if (q.kind > KIND_FLUSH) begin
            push_res(0, 0, IO_NONE, 0, 0, 0, 1);
        end else begin
            i = q.sel;
            if (q.kind == KIND_WNOW && tag_ok[i]) begin
                dirty_b[i] = 1'b0; done_b[i] = 1'b1;
                append_buf(i);
                push_res(i, 0, IO_WRITE, tag_dev[i], tag_blk[i], 0, 1);
            end else begin
                if (q.kind == KIND_DWR && tag_ok[i]) begin
                    dirty_b[i] = 1'b1; done_b[i] = 1'b1;
                end
                append_buf(i);
                push_res(i, 0, IO_NONE, 0, 0, 0, 1);
            end
        end
    endfunction

    function automatic void add_req(input logic [2:0] k, input logic [7:0] d,
                                    input logic [23:0] b, input logic [3:0] s,
                                    input bit drain);
        t_req q;
        q.kind = k; q.dev = d; q.blk = b; q.sel = s; q.drain = drain;
        pending_reqs.push_back(q);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) predict_cache(cur_req);
            if (src_gap > 0 && !calm) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain &&
                          (expected_results.size() != 0 || s_tvalid))) begin
                // hold the flagged request until every result is back
                s_tvalid <= 1'b0;
            end else begin
                cur_req = pending_reqs.pop_front();
                s_tdata <= {4'b0, cur_req.sel, cur_req.blk, cur_req.dev};
                s_tuser <= cur_req.kind;
                s_tvalid <= 1'b1;
                if (pending_reqs.size() < CALM_TAIL) calm <= 1'b1;
                src_gap <= ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge i_clk) begin
        t_exp e;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[3:0] !== e.idx)
                        report_mismatch($sformatf("buffer_index %0d exp %0d",
                                                  m_tdata[3:0], e.idx));
                    if (m_tdata[4] !== e.hit)
                        report_mismatch($sformatf("hit %b exp %b", m_tdata[4], e.hit));
                    if (m_tdata[6:5] !== e.op)
                        report_mismatch($sformatf("io_op %0d exp %0d", m_tdata[6:5], e.op));
                    if (m_tdata[14:7] !== e.dev)
                        report_mismatch($sformatf("io_device %h exp %h",
                                                  m_tdata[14:7], e.dev));
                    if (m_tdata[38:15] !== e.blk)
                        report_mismatch($sformatf("io_block %h exp %h",
                                                  m_tdata[38:15], e.blk));
                    if (m_tdata[39] !== e.status)
                        report_mismatch($sformatf("status %b exp %b", m_tdata[39], e.status));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("tlast %b exp %b", m_tlast, e.last));
                end
            end
            if (sink_gap > 0 && !calm) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 15);
            end
        end
    end

    initial begin
        int i;
        int k;
        for (i = 0; i < NUM_BUFFERS; i++) begin
            tag_dev[i] = '0; tag_blk[i] = '0; tag_ok[i] = 0;
            done_b[i] = 0; dirty_b[i] = 0; free_b[i] = 1;
            nxt_b[i] = 4'(i > 0 ? i - 1 : 0);
            prv_b[i] = 4'(i + 1 < NUM_BUFFERS ? i + 1 : 0);
        end
        head_b = 4'(NUM_BUFFERS - 1); tail_b = '0; free_cnt = NUM_BUFFERS;

        // drain the free list with distinct misses, then one more for busy
        add_req(KIND_READ, 8'hFF, 24'hFFFFFF, 4'hF, 0);
        for (i = 1; i < 17; i++) add_req(KIND_READ, 8'(i), 24'(i), 4'(i), 0);
        add_req(KIND_READ, 8'd1, 24'd1, 4'd0, 0);       // hit, already done
        add_req(KIND_DWR, 8'd0, 24'd0, 4'd3, 0);
        add_req(KIND_DWR, 8'd0, 24'd0, 4'd5, 0);
        add_req(KIND_WNOW, 8'd0, 24'd0, 4'd7, 0);
        add_req(KIND_REL, 8'd0, 24'd0, 4'd9, 0);
        add_req(KIND_REL, 8'd0, 24'd0, 4'd9, 0);        // already on the list
        add_req(KIND_READ, 8'd200, 24'd5, 4'd0, 0);     // miss on a dirty head
        add_req(KIND_FLUSH, 8'd10, 24'd0, 4'd0, 0);
        add_req(KIND_BAD, 8'd0, 24'd0, 4'd0, 1);

        for (i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40)
                add_req(KIND_READ,
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                        ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 7)),
                        4'($urandom), 0);
            else if (k < 85)
                add_req(3'($urandom_range(KIND_WNOW, KIND_REL)), 8'($urandom),
                        24'($urandom), 4'($urandom), i == 200);
            else if (k < 95)
                add_req(KIND_FLUSH,
                        ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                        24'($urandom), 4'($urandom), 0);
            else
                add_req(3'($urandom_range(5, 7)), 8'($urandom), 24'($urandom),
                        4'($urandom), 0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (s_tvalid || expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
